FILE: hdl/btp_pkg.sv
// Shared types and constants for the boolean tag infix-to-postfix unit.
// Token and result codes, command and status structs. No dependencies.
package btp_pkg;

	localparam int DEF_STACK_DEPTH  = 16;
	localparam int DEF_TAG_ID_WIDTH = 16;

	localparam int KIND_W   = 3;
	localparam int STATUS_W = 2;

	// token / result kinds
	localparam logic [KIND_W-1:0] K_TAG    = 3'd0;
	localparam logic [KIND_W-1:0] K_AND    = 3'd1;
	localparam logic [KIND_W-1:0] K_OR     = 3'd2;
	localparam logic [KIND_W-1:0] K_XOR    = 3'd3;
	localparam logic [KIND_W-1:0] K_NOT    = 3'd4;
	localparam logic [KIND_W-1:0] K_LPAREN = 3'd5;
	localparam logic [KIND_W-1:0] K_RPAREN = 3'd6;
	localparam logic [KIND_W-1:0] K_END    = 3'd7;
	localparam logic [KIND_W-1:0] K_MARK   = 3'd5;

	// error / status codes
	localparam logic [STATUS_W-1:0] ERR_NONE   = 2'd0;
	localparam logic [STATUS_W-1:0] ERR_SYNTAX = 2'd1;
	localparam logic [STATUS_W-1:0] ERR_OVF    = 2'd2;

	// result source select
	localparam logic [1:0] PS_TAG  = 2'd0;
	localparam logic [1:0] PS_TOP  = 2'd1;
	localparam logic [1:0] PS_NOT  = 2'd2;
	localparam logic [1:0] PS_MARK = 2'd3;

	typedef struct packed {
		logic       load_tok;
		logic       produce;
		logic [1:0] prod_sel;
		logic       finish;
		logic       push;
		logic       pop;
		logic       replace;
		logic       set_after;
		logic       clr_after;
		logic       set_err_syn;
		logic       set_err_ovf;
		logic       clear_all;
	} btp_cmd_t;

	typedef struct packed {
		logic [KIND_W-1:0]   tok_mode;
		logic [STATUS_W-1:0] err;
		logic                after;
		logic                count_nz;
		logic                count_full;
		logic                lparen_nz;
		logic [KIND_W-1:0]   top;
		logic                hold_valid;
		logic                out_free;
	} btp_sts_t;

endpackage

FILE: hdl/btp_tok_if.sv
// Token channel: valid/ready handshake with token kind and tag id.
// Depends on btp_pkg.
interface btp_tok_if #(
	parameter int TAG_ID_WIDTH = btp_pkg::DEF_TAG_ID_WIDTH
);
	logic                       valid;
	logic                       ready;
	logic [btp_pkg::KIND_W-1:0] mode;
	logic [TAG_ID_WIDTH-1:0]    tag_id;

	modport source (output valid, output mode, output tag_id, input ready);
	modport sink   (input valid, input mode, input tag_id, output ready);
endinterface

FILE: hdl/btp_res_if.sv
// Result channel: valid/ready handshake with postfix token, status, last.
// Depends on btp_pkg.
interface btp_res_if #(
	parameter int TAG_ID_WIDTH = btp_pkg::DEF_TAG_ID_WIDTH
);
	logic                         valid;
	logic                         ready;
	logic [btp_pkg::KIND_W-1:0]   out_kind;
	logic [TAG_ID_WIDTH-1:0]      out_tag_id;
	logic [btp_pkg::STATUS_W-1:0] status;
	logic                         last;

	modport source (output valid, output out_kind, output out_tag_id, output status,
		output last, input ready);
	modport sink   (input valid, input out_kind, input out_tag_id, input status,
		input last, output ready);
endinterface

FILE: hdl/btp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module btp_ram #(
	parameter int WIDTH = 3,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: hdl/btp_ctrl.sv
// Controller state machine for the infix-to-postfix unit.
// Depends on btp_pkg; drives btp_dp through btp_cmd_t, reads btp_sts_t.
module btp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  btp_pkg::btp_sts_t sts,
	output btp_pkg::btp_cmd_t cmd
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXEC = 3'd1;
	localparam logic [2:0] S_LOOP = 3'd2;
	localparam logic [2:0] S_WAIT = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;

	localparam logic [1:0] LK_NOT   = 2'd0;
	localparam logic [1:0] LK_PAREN = 2'd1;
	localparam logic [1:0] LK_DRAIN = 2'd2;

	logic [2:0] state_q, state_d;
	logic [1:0] loop_q, loop_d;
	logic       emit_ok, tok_bin, top_bin;

	assign emit_ok = !sts.hold_valid || sts.out_free;
	assign tok_bin = sts.tok_mode inside {btp_pkg::K_AND, btp_pkg::K_OR, btp_pkg::K_XOR};
	assign top_bin = sts.top inside {btp_pkg::K_AND, btp_pkg::K_OR, btp_pkg::K_XOR};

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		state_d  = state_q;
		loop_d   = loop_q;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_tok = 1'b1;
					state_d      = S_EXEC;
				end
			end
			S_EXEC: begin
				if (sts.tok_mode == btp_pkg::K_END) begin
					if (sts.err == btp_pkg::ERR_NONE &&
					    ((sts.after && sts.lparen_nz) || (!sts.after && sts.count_nz))) begin
						cmd.set_err_syn = 1'b1;
					end
					loop_d  = LK_DRAIN;
					state_d = S_LOOP;
				end else if (sts.err != btp_pkg::ERR_NONE) begin
					state_d = S_IDLE;
				end else if (!sts.after) begin
					if (sts.tok_mode == btp_pkg::K_TAG) begin
						if (emit_ok) begin
							cmd.produce   = 1'b1;
							cmd.prod_sel  = btp_pkg::PS_TAG;
							cmd.set_after = 1'b1;
							loop_d        = LK_NOT;
							state_d       = S_LOOP;
						end
					end else if (sts.tok_mode == btp_pkg::K_NOT ||
					             sts.tok_mode == btp_pkg::K_LPAREN) begin
						if (sts.count_full) begin
							cmd.set_err_ovf = 1'b1;
						end else begin
							cmd.push = 1'b1;
						end
						state_d = S_IDLE;
					end else begin
						cmd.set_err_syn = 1'b1;
						state_d         = S_IDLE;
					end
				end else begin
					if (tok_bin) begin
						if (sts.count_nz && top_bin) begin
							if (emit_ok) begin
								cmd.produce   = 1'b1;
								cmd.prod_sel  = btp_pkg::PS_TOP;
								cmd.replace   = 1'b1;
								cmd.clr_after = 1'b1;
								state_d       = S_FIN;
							end
						end else if (sts.count_full) begin
							cmd.set_err_ovf = 1'b1;
							state_d         = S_IDLE;
						end else begin
							cmd.push      = 1'b1;
							cmd.clr_after = 1'b1;
							state_d       = S_IDLE;
						end
					end else if (sts.tok_mode == btp_pkg::K_RPAREN) begin
						if (!sts.lparen_nz) begin
							cmd.set_err_syn = 1'b1;
							state_d         = S_IDLE;
						end else begin
							loop_d  = LK_PAREN;
							state_d = S_LOOP;
						end
					end else begin
						cmd.set_err_syn = 1'b1;
						state_d         = S_IDLE;
					end
				end
			end
			S_LOOP: begin
				case (loop_q)
					LK_NOT: begin
						if (sts.count_nz && sts.top == btp_pkg::K_NOT) begin
							if (emit_ok) begin
								cmd.produce  = 1'b1;
								cmd.prod_sel = btp_pkg::PS_NOT;
								cmd.pop      = 1'b1;
								state_d      = S_WAIT;
							end
						end else begin
							state_d = S_FIN;
						end
					end
					LK_PAREN: begin
						if (sts.top == btp_pkg::K_LPAREN) begin
							cmd.pop = 1'b1;
							loop_d  = LK_NOT;
							state_d = S_WAIT;
						end else if (emit_ok) begin
							cmd.produce  = 1'b1;
							cmd.prod_sel = btp_pkg::PS_TOP;
							cmd.pop      = 1'b1;
							state_d      = S_WAIT;
						end
					end
					LK_DRAIN: begin
						if (emit_ok) begin
							cmd.produce = 1'b1;
							if (sts.count_nz && sts.err == btp_pkg::ERR_NONE) begin
								cmd.prod_sel = btp_pkg::PS_TOP;
								cmd.pop      = 1'b1;
								state_d      = S_WAIT;
							end else begin
								cmd.prod_sel  = btp_pkg::PS_MARK;
								cmd.clear_all = 1'b1;
								state_d       = S_FIN;
							end
						end
					end
					default: begin
						state_d = S_FIN;
					end
				endcase
			end
			S_WAIT: begin
				state_d = S_LOOP;
			end
			S_FIN: begin
				if (emit_ok) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			loop_q  <= LK_NOT;
		end else begin
			state_q <= state_d;
			loop_q  <= loop_d;
		end
	end
endmodule

FILE: hdl/btp_dp.sv
// Datapath: token latch, operator stack (btp_ram), counters, flags,
// one-deep result hold and output register. Depends on btp_pkg, btp_ram.
module btp_dp #(
	parameter int STACK_DEPTH  = btp_pkg::DEF_STACK_DEPTH,
	parameter int TAG_ID_WIDTH = btp_pkg::DEF_TAG_ID_WIDTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  btp_pkg::btp_cmd_t            cmd,
	output btp_pkg::btp_sts_t            sts,
	input  logic [btp_pkg::KIND_W-1:0]   in_mode,
	input  logic [TAG_ID_WIDTH-1:0]      in_tag_id,
	input  logic                         out_ready,
	output logic                         out_valid,
	output logic [btp_pkg::KIND_W-1:0]   out_kind,
	output logic [TAG_ID_WIDTH-1:0]      out_tag_id,
	output logic [btp_pkg::STATUS_W-1:0] out_status,
	output logic                         out_last
);
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);

	logic [CW-1:0]                count_q, lpar_q, cnt_dec;
	logic                         after_q;
	logic [btp_pkg::STATUS_W-1:0] err_q;
	logic [btp_pkg::KIND_W-1:0]   tok_mode_q;
	logic [TAG_ID_WIDTH-1:0]      tok_tag_q;
	logic [btp_pkg::KIND_W-1:0]   top;
	logic [AW-1:0]                top_addr, waddr;
	logic                         we;

	logic                         hold_valid_q;
	logic [btp_pkg::KIND_W-1:0]   hold_kind_q, new_kind;
	logic [TAG_ID_WIDTH-1:0]      hold_tag_q, new_tag;
	logic [btp_pkg::STATUS_W-1:0] hold_status_q, new_status;
	logic                         out_valid_q, out_last_q, move;
	logic [btp_pkg::KIND_W-1:0]   out_kind_q;
	logic [TAG_ID_WIDTH-1:0]      out_tag_q;
	logic [btp_pkg::STATUS_W-1:0] out_status_q;

	assign cnt_dec  = count_q - CW'(1);
	assign top_addr = cnt_dec[AW-1:0];
	assign we       = cmd.push || cmd.replace;
	assign waddr    = cmd.push ? count_q[AW-1:0] : top_addr;

	btp_ram #(
		.WIDTH (btp_pkg::KIND_W),
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (tok_mode_q),
		.raddr (top_addr),
		.rdata (top)
	);

	always_ff @(posedge clk) begin
		if (cmd.load_tok) begin
			tok_mode_q <= in_mode;
			tok_tag_q  <= in_tag_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			lpar_q  <= '0;
			after_q <= 1'b0;
			err_q   <= btp_pkg::ERR_NONE;
		end else if (cmd.clear_all) begin
			count_q <= '0;
			lpar_q  <= '0;
			after_q <= 1'b0;
			err_q   <= btp_pkg::ERR_NONE;
		end else begin
			if (cmd.push) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.pop) begin
				count_q <= cnt_dec;
			end
			if (cmd.push && tok_mode_q == btp_pkg::K_LPAREN) begin
				lpar_q <= lpar_q + CW'(1);
			end else if (cmd.pop && top == btp_pkg::K_LPAREN) begin
				lpar_q <= lpar_q - CW'(1);
			end
			if (cmd.set_after) begin
				after_q <= 1'b1;
			end else if (cmd.clr_after) begin
				after_q <= 1'b0;
			end
			if (cmd.set_err_syn) begin
				err_q <= btp_pkg::ERR_SYNTAX;
			end else if (cmd.set_err_ovf) begin
				err_q <= btp_pkg::ERR_OVF;
			end
		end
	end

	always_comb begin
		new_kind   = top;
		new_tag    = '0;
		new_status = btp_pkg::ERR_NONE;
		case (cmd.prod_sel)
			btp_pkg::PS_TAG: begin
				new_kind = btp_pkg::K_TAG;
				new_tag  = tok_tag_q;
			end
			btp_pkg::PS_TOP: begin
				new_kind = top;
			end
			btp_pkg::PS_NOT: begin
				new_kind = btp_pkg::K_NOT;
			end
			btp_pkg::PS_MARK: begin
				new_kind   = btp_pkg::K_MARK;
				new_status = err_q;
			end
			default: begin
				new_kind = top;
			end
		endcase
	end

	// held result moves out when a newer one arrives or the token finishes
	assign move = hold_valid_q && (cmd.produce || cmd.finish);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.produce) begin
				hold_valid_q <= 1'b1;
			end else if (cmd.finish) begin
				hold_valid_q <= 1'b0;
			end
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.produce) begin
			hold_kind_q   <= new_kind;
			hold_tag_q    <= new_tag;
			hold_status_q <= new_status;
		end
		if (move) begin
			out_kind_q   <= hold_kind_q;
			out_tag_q    <= hold_tag_q;
			out_status_q <= hold_status_q;
			out_last_q   <= cmd.finish;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_kind   = out_kind_q;
	assign out_tag_id = out_tag_q;
	assign out_status = out_status_q;
	assign out_last   = out_last_q;

	assign sts.tok_mode   = tok_mode_q;
	assign sts.err        = err_q;
	assign sts.after      = after_q;
	assign sts.count_nz   = (count_q != '0);
	assign sts.count_full = (count_q == CW'(STACK_DEPTH));
	assign sts.lparen_nz  = (lpar_q != '0);
	assign sts.top        = top;
	assign sts.hold_valid = hold_valid_q;
	assign sts.out_free   = !out_valid_q || out_ready;
endmodule

FILE: hdl/boolean_tag_infix_to_postfix_unit.sv
// Boolean tag infix-to-postfix unit: accepts one lexed token per transaction on
// "tokens" and returns the postfix stream on "results". A token is latched in
// IDLE and evaluated in EXEC, from which one that pushes an operator or sets an
// error goes back to IDLE and one that emits results goes on to LOOP or FIN.
// Each entry popped from the operator stack (closing parenthesis, pending nots,
// end-of-expression drain) is followed by a WAIT state, as the stack lives in a
// RAM whose top is read through its registered port. Each token's last result
// is held so its last flag is exact; a full output register stalls the unit.
// Depends on btp_pkg, btp_tok_if, btp_res_if, btp_ctrl, btp_dp, btp_ram.
module boolean_tag_infix_to_postfix_unit #(
	parameter int STACK_DEPTH  = btp_pkg::DEF_STACK_DEPTH,
	parameter int TAG_ID_WIDTH = btp_pkg::DEF_TAG_ID_WIDTH
) (
	input  logic             clk,
	input  logic             arst_n,
	btp_tok_if.sink          tokens,
	btp_res_if.source        results
);
	btp_pkg::btp_cmd_t cmd;
	btp_pkg::btp_sts_t sts;

	btp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (tokens.valid),
		.in_ready (tokens.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	btp_dp #(
		.STACK_DEPTH  (STACK_DEPTH),
		.TAG_ID_WIDTH (TAG_ID_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_mode    (tokens.mode),
		.in_tag_id  (tokens.tag_id),
		.out_ready  (results.ready),
		.out_valid  (results.valid),
		.out_kind   (results.out_kind),
		.out_tag_id (results.out_tag_id),
		.out_status (results.status),
		.out_last   (results.last)
	);

`ifndef ASSERT_OFF
	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> !sts.count_full)
		else $error("push on full operator stack");

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> sts.count_nz)
		else $error("pop on empty operator stack");

	a_produce_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.produce || cmd.finish) && sts.hold_valid |-> sts.out_free)
		else $error("held result overwritten while output is full");

	a_accept_clean: assert property (@(posedge clk) disable iff (!arst_n)
		tokens.valid && tokens.ready |-> !sts.hold_valid)
		else $error("token accepted with a result still held");

	a_marker_last: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.out_kind == btp_pkg::K_MARK |-> results.last)
		else $error("end marker not flagged last");
`endif
endmodule
